// ----- src/bsmrh_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte stream hash package
// Shared constants, controller state codes, and the command and status
// records that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package bsmrh_pkg;

  // Hash primes
  localparam logic [31:0] Prime1 = 32'd2654435761;
  localparam logic [31:0] Prime2 = 32'd2246822519;
  localparam logic [31:0] Prime5 = 32'd374761393;

  // Configuration address decode: word index above the byte offset
  localparam int unsigned AddrWidth = 3;
  localparam logic [AddrWidth-3:0] RegSeed = 1'b0;

  // Controller states, one-hot
  typedef enum logic [5:0] {
    StIdle    = 6'b000001,
    StWordRot = 6'b000010,
    StWordMul = 6'b000100,
    StTailMul = 6'b001000,
    StTailRot = 6'b010000,
    StEmit    = 6'b100000
  } bsmrh_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;    // take an item: start message, buffer byte, word multiply
    logic word_rot;  // add word product and rotate left by 13
    logic word_mul;  // multiply by prime2 into the accumulator
    logic tail_mul;  // multiply the oldest leftover byte by prime5
    logic tail_rot;  // add byte product and rotate left by 11, drop the byte
    logic emit;      // load the result register and close the message
  } bsmrh_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [1:0] pend_cnt;  // buffered bytes, zero outside a message
  } bsmrh_status_t;

  // Rotate left by 13
  function automatic logic [31:0] rotl13(input logic [31:0] x);
    return {x[18:0], x[31:19]};
  endfunction

  // Rotate left by 11
  function automatic logic [31:0] rotl11(input logic [31:0] x);
    return {x[20:0], x[31:21]};
  endfunction

endpackage

// ----- src/bsmrh_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte stream hash datapath
// Seed register, accumulator, byte buffer, one shared 32x32 multiplier with a
// product register, and the result register.
// ----------------------------------------------------------------------------
module bsmrh_datapath (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  bsmrh_pkg::bsmrh_cmd_t    cmd_i,
  output bsmrh_pkg::bsmrh_status_t status_o,
  input  logic [7:0]              data_byte_i,
  input  logic                    byte_present_i,
  input  logic                    seed_we_i,
  input  logic [31:0]             seed_wdata_i,
  output logic [31:0]             seed_o,
  output logic [31:0]             hash_value_o
);
  import bsmrh_pkg::*;

  logic [31:0] seed_q, seed_d;
  logic [31:0] acc_q, acc_d;
  logic [23:0] pend_q, pend_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        in_msg_q, in_msg_d;
  logic [31:0] tmp_q, tmp_d;
  logic [31:0] hash_q, hash_d;

  logic [31:0] acc_base;
  logic [23:0] pend_base;
  logic [1:0]  cnt_base;
  logic [31:0] mul_a, mul_b, mul_res;

  // Values at message start: fresh accumulator and empty buffer
  always_comb begin
    acc_base  = in_msg_q ? acc_q : seed_q + Prime5;
    pend_base = in_msg_q ? pend_q : 24'd0;
    cnt_base  = in_msg_q ? cnt_q : 2'd0;
  end

  // Shared multiplier, low 32 bits of the product
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    if (cmd_i.accept) begin
      mul_a = {data_byte_i, pend_base};
      mul_b = Prime1;
    end else if (cmd_i.word_mul) begin
      mul_a = tmp_q;
      mul_b = Prime2;
    end else if (cmd_i.tail_mul) begin
      mul_a = {24'd0, pend_q[7:0]};
      mul_b = Prime5;
    end
  end
  assign mul_res = mul_a * mul_b;

  // Next state of the datapath registers
  always_comb begin
    seed_d   = seed_we_i ? seed_wdata_i : seed_q;
    acc_d    = acc_q;
    pend_d   = pend_q;
    cnt_d    = cnt_q;
    in_msg_d = in_msg_q;
    tmp_d    = tmp_q;
    hash_d   = hash_q;
    if (cmd_i.accept) begin
      acc_d    = acc_base;
      pend_d   = pend_base;
      cnt_d    = cnt_base;
      in_msg_d = 1'b1;
      if (byte_present_i) begin
        case (cnt_base)
          2'd0: begin
            pend_d[7:0] = data_byte_i;
            cnt_d       = 2'd1;
          end
          2'd1: begin
            pend_d[15:8] = data_byte_i;
            cnt_d        = 2'd2;
          end
          2'd2: begin
            pend_d[23:16] = data_byte_i;
            cnt_d         = 2'd3;
          end
          default: begin
            // fourth byte completes a word: product goes to tmp
            tmp_d  = mul_res;
            pend_d = 24'd0;
            cnt_d  = 2'd0;
          end
        endcase
      end
    end
    if (cmd_i.word_rot) begin
      tmp_d = rotl13(acc_q + tmp_q);
    end
    if (cmd_i.word_mul) begin
      acc_d = mul_res;
    end
    if (cmd_i.tail_mul) begin
      tmp_d = mul_res;
    end
    if (cmd_i.tail_rot) begin
      acc_d  = rotl11(acc_q + tmp_q);
      pend_d = {8'd0, pend_q[23:8]};
      cnt_d  = cnt_q - 2'd1;
    end
    if (cmd_i.emit) begin
      hash_d   = acc_q;
      pend_d   = 24'd0;
      cnt_d    = 2'd0;
      in_msg_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q   <= 32'd0;
      acc_q    <= Prime5;
      pend_q   <= 24'd0;
      cnt_q    <= 2'd0;
      in_msg_q <= 1'b0;
    end else begin
      seed_q   <= seed_d;
      acc_q    <= acc_d;
      pend_q   <= pend_d;
      cnt_q    <= cnt_d;
      in_msg_q <= in_msg_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    tmp_q  <= tmp_d;
    hash_q <= hash_d;
  end

  assign status_o.pend_cnt = cnt_base;
  assign seed_o            = seed_q;
  assign hash_value_o      = hash_q;

  // A completed word empties the buffer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.accept && byte_present_i && cnt_base == 2'd3) |=> (cnt_q == 2'd0))
    else $error("buffer not emptied after word");

  // Closing a message leaves nothing buffered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> (!in_msg_q && cnt_q == 2'd0 && pend_q == 24'd0))
    else $error("message state left after emit");

endmodule

// ----- src/bsmrh_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte stream hash controller
// Sequences the word step, the leftover byte folds and the result handoff,
// and owns the result valid flag.
// ----------------------------------------------------------------------------
module bsmrh_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    byte_present_i,
  input  logic                    last_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  input  bsmrh_pkg::bsmrh_status_t status_i,
  output bsmrh_pkg::bsmrh_cmd_t    cmd_o
);
  import bsmrh_pkg::*;

  bsmrh_state_e state_q, state_d;
  logic         last_q, last_d;
  logic         out_valid_q, out_valid_d;
  logic         take;
  logic         slot_free;

  assign in_ready_o = (state_q == StIdle);
  // Idle items are taken but do nothing
  assign take       = in_valid_i && in_ready_o && (byte_present_i || last_i);
  assign slot_free  = !out_valid_q || out_ready_i;

  // Advance the sequencer
  always_comb begin
    state_d = state_q;
    last_d  = last_q;
    case (state_q)
      StIdle: begin
        if (take) begin
          last_d = last_i;
          if (byte_present_i && status_i.pend_cnt == 2'd3) begin
            state_d = StWordRot;
          end else if (last_i) begin
            state_d = (byte_present_i || status_i.pend_cnt != 2'd0) ? StTailMul : StEmit;
          end
        end
      end
      StWordRot: state_d = StWordMul;
      StWordMul: state_d = last_q ? StEmit : StIdle;
      StTailMul: state_d = StTailRot;
      StTailRot: state_d = (status_i.pend_cnt == 2'd1) ? StEmit : StTailMul;
      StEmit: begin
        if (slot_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd_o.accept   = take;
    cmd_o.word_rot = (state_q == StWordRot);
    cmd_o.word_mul = (state_q == StWordMul);
    cmd_o.tail_mul = (state_q == StTailMul);
    cmd_o.tail_rot = (state_q == StTailRot);
    cmd_o.emit     = (state_q == StEmit) && slot_free;
  end

  // Hold the result valid until the item is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A full result slot holds the sequencer in emit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit && out_valid_q && !out_ready_i) |=> (state_q == StEmit))
    else $error("emit left while result slot full");

  // A byte fold always has a byte to fold
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StTailRot) |-> (status_i.pend_cnt != 2'd0))
    else $error("tail fold with empty buffer");

  // Emit always presents a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> out_valid_q)
    else $error("result not presented after emit");

endmodule

// ----- src/byte_stream_multiply_rotate_hash_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte stream multiply rotate hash unit
// Hashes a message that arrives one byte per item; every fourth byte folds a
// little-endian word by multiply and rotate, leftover bytes fold on the last
// item, and the 32-bit hash is then delivered.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  input     in         in_valid_i / in_ready_o   data_byte_i, byte_present_i, last_i
//  result    out        out_valid_o / out_ready_i hash_value_o
//  config    in         psel/penable/pwrite       paddr, pwdata, prdata (seed at 0x0)
//
//  A byte that does not complete a word is taken in the idle state; a word-completing
//  byte runs word product, rotate and prime2 steps, bound by the shared multiplier.
//  A last item adds a multiply and a rotate step per leftover byte (0 to 3), then emit.
//  Reset clears the seed to 0 and ends any message; no clearing pass.
//  The result register frees the input side: the next message streams in while
//  a hash waits, and the sequencer stalls only at its next emit.
// ----------------------------------------------------------------------------
module byte_stream_multiply_rotate_hash_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      data_byte_i,
  input  logic                            byte_present_i,
  input  logic                            last_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [31:0]                     hash_value_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bsmrh_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import bsmrh_pkg::*;

  bsmrh_cmd_t    cmd;
  bsmrh_status_t status;
  logic          seed_hit;
  logic          seed_we;
  logic [31:0]   seed;

  // Decode the configuration port
  assign pready   = 1'b1;
  assign seed_hit = (paddr[AddrWidth-1:2] == RegSeed);
  assign seed_we  = psel && penable && pwrite && pready && seed_hit;
  assign prdata   = seed_hit ? seed : 32'd0;

  bsmrh_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .byte_present_i (byte_present_i),
    .last_i         (last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_i       (status),
    .cmd_o          (cmd)
  );

  bsmrh_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .data_byte_i    (data_byte_i),
    .byte_present_i (byte_present_i),
    .seed_we_i      (seed_we),
    .seed_wdata_i   (pwdata),
    .seed_o         (seed),
    .hash_value_o   (hash_value_o)
  );

endmodule

// ----- sim/byte_stream_multiply_rotate_hash_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte stream multiply rotate hash unit testbench
// Streams byte messages into the hash unit under random valid and ready
// gaps and checks every delivered hash against a model of the word fold and
// the leftover byte fold. The seed register is reprogrammed between phases,
// including in the middle of an open message, and read back each time.
// ----------------------------------------------------------------------------
module byte_stream_multiply_rotate_hash_unit_tb;
  import bsmrh_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned SettleCycles = 16;
  localparam logic [AddrWidth-1:0] SeedAddr = {RegSeed, 2'b00};

  // Running hash model and the queue of hashes still owed by the block
  class hash_scoreboard;
    logic [31:0] seed;
    logic [31:0] acc;
    logic [23:0] held_bytes;
    logic [1:0]  held_count;
    bit          in_msg;
    logic [31:0] expected_hashes[$];
    int unsigned errors;
    int unsigned hashes_seen;
    int unsigned bytes_seen;

    function new();
      seed = '0;
      acc = Prime5;
      held_bytes = '0;
      held_count = '0;
      in_msg = 1'b0;
      errors = 0;
      hashes_seen = 0;
      bytes_seen = 0;
    endfunction

    static function logic [31:0] rotate_left(input logic [31:0] x, input int unsigned r);
      return (x << r) | (x >> (32 - r));
    endfunction

    // Fold one accepted item into the running hash; queue a hash on last
    function void note_item(input logic [7:0] b, input logic present, input logic ends);
      logic [31:0] word;
      int unsigned k;
      if (!present && !ends) return;
      if (!in_msg) begin
        acc = seed + Prime5;
        held_bytes = '0;
        held_count = '0;
        in_msg = 1'b1;
      end
      if (present) begin
        bytes_seen++;
        if (held_count == 2'd3) begin
          word = {b, held_bytes};
          acc = rotate_left(acc + word * Prime1, 13) * Prime2;
          held_bytes = '0;
          held_count = '0;
        end else begin
          held_bytes = held_bytes | (24'(b) << (8 * held_count));
          held_count = held_count + 2'd1;
        end
      end
      if (!ends) return;
      for (k = 0; k < held_count; k++) begin
        acc = rotate_left(acc + 32'(held_bytes[8*k +: 8]) * Prime5, 11);
      end
      expected_hashes.push_back(acc);
      held_bytes = '0;
      held_count = '0;
      in_msg = 1'b0;
    endfunction

    // Compare a delivered hash with the oldest one owed
    function void check_hash(input logic [31:0] got);
      logic [31:0] want;
      if (expected_hashes.size() == 0) begin
        $error("hash_value: no hash expected, got %h", got);
        errors++;
        return;
      end
      want = expected_hashes.pop_front();
      hashes_seen++;
      if (got !== want) begin
        $error("hash_value: expected %h, got %h", want, got);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           data_byte = '0;
  logic                 byte_present = 1'b0;
  logic                 last = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [31:0]          hash_value;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  bit             calm = 1'b0;
  int unsigned    cycles = 0;
  int unsigned    items_sent = 0;
  int unsigned    seeds_written = 0;
  hash_scoreboard sb = new();

  byte_stream_multiply_rotate_hash_unit dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .data_byte_i    (data_byte),
    .byte_present_i (byte_present),
    .last_i         (last),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .hash_value_o   (hash_value),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #5 clk = ~clk;

  // Stall the result side at random unless in a calm stretch
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 13);
  end

  // Watch both handshakes at each edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_hash(hash_value);
      if (in_valid && in_ready) sb.note_item(data_byte, byte_present, last);
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("byte_stream_multiply_rotate_hash_unit_tb: done, errors");
      $finish;
    end
  end

  // Offer one item, with a random gap first, and hold it until accepted
  task automatic send_item(input logic [7:0] b, input logic present, input logic ends);
    while (!calm && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    byte_present <= present;
    last <= ends;
    do @(posedge clk); while (!in_ready);
    if (present || ends) items_sent++;
  endtask

  // Drain owed hashes, then give the sequencer time to finish its work
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_hashes.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Write the seed register, then read it back
  task automatic write_seed(input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= SeedAddr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.seed = value;
    seeds_written++;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== value) begin
      $error("seed: expected %h, got %h", value, prdata);
      sb.errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // One message of random bytes, mostly short, with stray idle items inside
  task automatic random_message();
    int unsigned len;
    int unsigned i;
    bit          tail_empty;
    len = ($urandom_range(99) < 8) ? $urandom_range(40, 13) : $urandom_range(12, 0);
    tail_empty = (len == 0) || ($urandom_range(99) < 30);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(99) < 5) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      send_item(8'($urandom_range(255)), 1'b1, !tail_empty && (i == len - 1));
    end
    if (tail_empty) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  // Random traffic until the item budget of this phase is spent
  task automatic random_phase(input int unsigned budget);
    int unsigned stop_at;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 6) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      else random_message();
    end
  endtask

  initial begin
    int unsigned phase;
    int unsigned n;
    logic [31:0] phase_seed;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset seed, idle item, empty message, single byte
    send_item(8'hA5, 1'b0, 1'b0);
    send_item(8'h5A, 1'b0, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    // Word completed on the last item, no leftovers
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'hAA, 1'b1, 1'b0);
    send_item(8'h55, 1'b1, 1'b1);
    // Three leftovers, ended without a byte
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'h02, 1'b1, 1'b0);
    send_item(8'h03, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b1);
    settle();
    write_seed(32'hFFFF_FFFF);
    // Empty message under the top seed, then a seed change mid-message
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h7F, 1'b1, 1'b0);
    settle();
    write_seed(32'h1234_5678);
    send_item(8'hFE, 1'b1, 1'b0);
    send_item(8'h01, 1'b0, 1'b0);
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'h10, 1'b1, 1'b1);
    send_item(8'h3C, 1'b0, 1'b1);
    settle();

    // Random phases over several seeds; leave a message open at some edges
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: phase_seed = $urandom;
        1: phase_seed = 32'hFFFF_FFFF;
        2: phase_seed = 32'h0000_0000;
        default: phase_seed = $urandom;
      endcase
      write_seed(phase_seed);
      calm = (phase == 2);
      random_phase(406);
      if (phase % 2 == 1) begin
        n = $urandom_range(6, 1);
        repeat (n) send_item(8'($urandom_range(255)), 1'b1, 1'b0);
      end
      settle();
    end
    calm = 1'b0;
    send_item(8'h00, 1'b0, 1'b1);
    settle();

    $display("Covered %0d messages, %0d bytes, %0d seed writes.",
             sb.hashes_seen, sb.bytes_seen, seeds_written);
    if (sb.expected_hashes.size() != 0) begin
      $error("hash_value: %0d hashes never arrived", sb.expected_hashes.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("byte_stream_multiply_rotate_hash_unit_tb: done, clean");
    end else begin
      $display("byte_stream_multiply_rotate_hash_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
